FILE: design/mfde_pkg.sv
// ----------------------------------------------------------------------------
// mfde_pkg: shared definitions of the framebuffer draw engine
// Field widths, command codes, default geometry and the clip result type.
// ----------------------------------------------------------------------------
package mfde_pkg;

    // default screen geometry
    localparam int DEF_WIDTH_PX  = 84;
    localparam int DEF_HEIGHT_PX = 48;

    // field widths
    localparam int ACTION_W   = 3;
    localparam int COORD_W    = 8;
    localparam int ADDR_IN_W  = 9;
    localparam int DATA_W     = 8;
    localparam int PAGE_IDX_W = 5;
    localparam int ROW_IDX_W  = 3;

    // command codes
    localparam logic [ACTION_W-1:0] ACT_PIXEL   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_OUTLINE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FILL    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SCROLL  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_READ    = 3'd5;

    // clipped rectangle: column range, page range, first and last row in page
    typedef struct packed {
        logic                  empty;
        logic [COORD_W-1:0]    x0;
        logic [COORD_W-1:0]    x1;
        logic [PAGE_IDX_W-1:0] p0;
        logic [PAGE_IDX_W-1:0] p1;
        logic [ROW_IDX_W-1:0]  lo;
        logic [ROW_IDX_W-1:0]  hi;
    } t_clip;

endpackage

FILE: design/mfde_if.sv
// ----------------------------------------------------------------------------
// mfde_if: command and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mfde_cmd_if import mfde_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [COORD_W-1:0]    pos_x;
    logic [COORD_W-1:0]    pos_y;
    logic [COORD_W-1:0]    rect_w;
    logic [COORD_W-1:0]    rect_h;
    logic                  ink;
    logic [ADDR_IN_W-1:0]  read_addr;

    modport source (output valid, action, pos_x, pos_y, rect_w, rect_h, ink, read_addr,
                    input ready);
    modport sink   (input valid, action, pos_x, pos_y, rect_w, rect_h, ink, read_addr,
                    output ready);
endinterface

interface mfde_rsp_if import mfde_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

FILE: design/mono_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine: page-organized monochrome framebuffer
// Pixel, outline, fill, clear, scroll and read commands on a byte store.
// ----------------------------------------------------------------------------
// One command at a time; a pixel, outline or fill byte is a read-modify-write
// over the store's read and write ports. A fill walks each page's columns and
// an outline its top, bottom, left and right edges in turn; every result
// goes through the response register. After reset a clearing pass
// writes the STORE bytes (504 at 84 x 48) before the first command is taken.
module mono_framebuffer_draw_engine import mfde_pkg::*; #(
    parameter int WIDTH_PX  = DEF_WIDTH_PX,
    parameter int HEIGHT_PX = DEF_HEIGHT_PX
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mfde_cmd_if.sink   i_cmd,
    mfde_rsp_if.source o_rsp
);

    localparam int PAGES    = (HEIGHT_PX + 7) / 8;
    localparam int STORE    = WIDTH_PX * PAGES;
    localparam int ADDR_W   = $clog2(STORE);
    localparam int CMP_W    = ((ADDR_W > ADDR_IN_W) ? ADDR_W : ADDR_IN_W) + 1;
    localparam int COPY_END = (PAGES > 1) ? (STORE - WIDTH_PX - 1) : 0;

    typedef enum logic [10:0] {
        S_INIT   = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_SETUP  = 11'b000_0000_0100,
        S_SEEK   = 11'b000_0000_1000,
        S_RD     = 11'b000_0001_0000,
        S_WR     = 11'b000_0010_0000,
        S_SCR_RD = 11'b000_0100_0000,
        S_SCR_WR = 11'b000_1000_0000,
        S_ZERO   = 11'b001_0000_0000,
        S_RDW    = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [ACTION_W-1:0]   r_action, n_action;
    logic [COORD_W-1:0]    r_x, n_x;
    logic [COORD_W-1:0]    r_y, n_y;
    logic [COORD_W-1:0]    r_w, n_w;
    logic [COORD_W-1:0]    r_h, n_h;
    logic                  r_ink, n_ink;
    logic [1:0]            r_edge, n_edge;
    logic [COORD_W-1:0]    r_col, n_col;
    logic [COORD_W-1:0]    r_x0, n_x0;
    logic [COORD_W-1:0]    r_x1, n_x1;
    logic [PAGE_IDX_W-1:0] r_page, n_page;
    logic [PAGE_IDX_W-1:0] r_p0, n_p0;
    logic [PAGE_IDX_W-1:0] r_p1, n_p1;
    logic [ROW_IDX_W-1:0]  r_lo, n_lo;
    logic [ROW_IDX_W-1:0]  r_hi, n_hi;
    logic [ADDR_W-1:0]     r_base, n_base;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [ADDR_W-1:0]     r_waddr, n_waddr;
    logic [DATA_W-1:0]     r_result, n_result;
    logic                  r_out_valid, n_out_valid;
    logic [DATA_W-1:0]     r_out_data, n_out_data;

    logic [COORD_W:0]      rect_xs;
    logic [COORD_W:0]      rect_ys;
    logic [COORD_W-1:0]    rect_w;
    logic [COORD_W-1:0]    rect_h;
    t_clip                 clip;

    logic [ADDR_W-1:0]     opa, opb, sum;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_W-1:0]     mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [DATA_W-1:0]     mem_rdata;

    logic [CMP_W-1:0]      rd_addr_ext;
    logic                  rd_in_range;
    logic                  last_edge;
    logic [DATA_W-1:0]     mask_lo, mask_hi, mask;
    logic                  cmd_fire;

    // rectangle for the current command or outline edge
    always_comb begin
        rect_xs = {1'b0, r_x};
        rect_ys = {1'b0, r_y};
        rect_w  = r_w;
        rect_h  = r_h;
        case (r_action)
            ACT_PIXEL: begin
                rect_w = COORD_W'(1);
                rect_h = COORD_W'(1);
            end
            ACT_OUTLINE: begin
                case (r_edge)
                    2'd0: rect_h = COORD_W'(1);
                    2'd1: begin
                        rect_ys = {1'b0, r_y} + {1'b0, r_h} - (COORD_W + 1)'(1);
                        rect_h  = COORD_W'(1);
                    end
                    2'd2: rect_w = COORD_W'(1);
                    default: begin
                        rect_xs = {1'b0, r_x} + {1'b0, r_w} - (COORD_W + 1)'(1);
                        rect_w  = COORD_W'(1);
                    end
                endcase
            end
            default: ;
        endcase
    end

    mfde_clip #(
        .WIDTH_PX  (WIDTH_PX),
        .HEIGHT_PX (HEIGHT_PX)
    ) u_clip (
        .i_xs   (rect_xs),
        .i_ys   (rect_ys),
        .i_ew   (rect_w),
        .i_eh   (rect_h),
        .o_clip (clip)
    );

    // shared address adder
    always_comb begin
        opa = (r_state == S_SCR_RD) ? r_addr : r_base;
        opb = (r_state == S_RD) ? ADDR_W'(r_col) : ADDR_W'(WIDTH_PX);
        sum = opa + opb;
    end

    // read address check and row mask of the current page
    assign rd_addr_ext = CMP_W'(i_cmd.read_addr);
    assign rd_in_range = rd_addr_ext < CMP_W'(STORE);
    assign last_edge   = (r_action != ACT_OUTLINE) || (r_edge == 2'd3);
    assign mask_lo     = (r_page == r_p0) ? (8'hff << r_lo) : 8'hff;
    assign mask_hi     = (r_page == r_p1) ? (8'hff >> (3'd7 - r_hi)) : 8'hff;
    assign mask        = mask_lo & mask_hi;

    // store ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        case (r_state)
            S_INIT, S_ZERO: mem_we = 1'b1;
            S_SCR_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_waddr;
                mem_wdata = r_ink ? (mem_rdata | mask) : (mem_rdata & ~mask);
            end
            default: ;
        endcase
        case (r_state)
            S_IDLE:           mem_raddr = rd_addr_ext[ADDR_W-1:0];
            S_RD, S_SCR_RD:   mem_raddr = sum;
            default:          mem_raddr = r_addr;
        endcase
    end

    mfde_ram #(
        .DEPTH  (STORE),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_cmd.ready     = (r_state == S_IDLE);
    assign cmd_fire        = i_cmd.valid && i_cmd.ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_x         = r_x;
        n_y         = r_y;
        n_w         = r_w;
        n_h         = r_h;
        n_ink       = r_ink;
        n_edge      = r_edge;
        n_col       = r_col;
        n_x0        = r_x0;
        n_x1        = r_x1;
        n_page      = r_page;
        n_p0        = r_p0;
        n_p1        = r_p1;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_base      = r_base;
        n_addr      = r_addr;
        n_waddr     = r_waddr;
        n_result    = r_result;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_data  = r_out_data;

        case (r_state)
            // clearing pass after reset
            S_INIT: begin
                n_addr = r_addr + ADDR_W'(1);
                if (r_addr == ADDR_W'(STORE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            // take a command beat
            S_IDLE: begin
                if (cmd_fire) begin
                    n_action = i_cmd.action;
                    n_x      = i_cmd.pos_x;
                    n_y      = i_cmd.pos_y;
                    n_w      = i_cmd.rect_w;
                    n_h      = i_cmd.rect_h;
                    n_ink    = i_cmd.ink;
                    n_edge   = '0;
                    n_result = '0;
                    n_addr   = '0;
                    case (i_cmd.action)
                        ACT_PIXEL, ACT_FILL: n_state = S_SETUP;
                        ACT_OUTLINE: begin
                            n_state = ((i_cmd.rect_w == '0) || (i_cmd.rect_h == '0))
                                      ? S_DONE : S_SETUP;
                        end
                        ACT_CLEAR:  n_state = S_ZERO;
                        ACT_SCROLL: n_state = (PAGES > 1) ? S_SCR_RD : S_ZERO;
                        ACT_READ:   n_state = rd_in_range ? S_RDW : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            // clip the current rectangle
            S_SETUP: begin
                if (clip.empty) begin
                    if (last_edge) begin
                        n_state = S_DONE;
                    end else begin
                        n_edge = r_edge + 2'd1;
                    end
                end else begin
                    n_x0    = clip.x0;
                    n_x1    = clip.x1;
                    n_p0    = clip.p0;
                    n_p1    = clip.p1;
                    n_lo    = clip.lo;
                    n_hi    = clip.hi;
                    n_col   = clip.x0;
                    n_page  = '0;
                    n_base  = '0;
                    n_state = S_SEEK;
                end
            end
            // step the page base up to the first page
            S_SEEK: begin
                if (r_page == r_p0) begin
                    n_state = S_RD;
                end else begin
                    n_page = r_page + PAGE_IDX_W'(1);
                    n_base = sum;
                end
            end
            S_RD: begin
                n_waddr = sum;
                n_state = S_WR;
            end
            // merge the mask and walk columns, then pages
            S_WR: begin
                if (r_col != r_x1) begin
                    n_col   = r_col + COORD_W'(1);
                    n_state = S_RD;
                end else if (r_page != r_p1) begin
                    n_col   = r_x0;
                    n_page  = r_page + PAGE_IDX_W'(1);
                    n_base  = sum;
                    n_state = S_RD;
                end else if (last_edge) begin
                    n_state = S_DONE;
                end else begin
                    n_edge  = r_edge + 2'd1;
                    n_state = S_SETUP;
                end
            end
            // scroll copy: each byte takes the byte one page further on in the store
            S_SCR_RD: n_state = S_SCR_WR;
            S_SCR_WR: begin
                n_addr  = r_addr + ADDR_W'(1);
                n_state = (r_addr == ADDR_W'(COPY_END)) ? S_ZERO : S_SCR_RD;
            end
            // zero sweep to the end of the store
            S_ZERO: begin
                n_addr = r_addr + ADDR_W'(1);
                if (r_addr == ADDR_W'(STORE - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_RDW: begin
                n_result = mem_rdata;
                n_state  = S_DONE;
            end
            // hand the result to the response register
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_x        <= n_x;
        r_y        <= n_y;
        r_w        <= n_w;
        r_h        <= n_h;
        r_ink      <= n_ink;
        r_edge     <= n_edge;
        r_col      <= n_col;
        r_x0       <= n_x0;
        r_x1       <= n_x1;
        r_page     <= n_page;
        r_p0       <= n_p0;
        r_p1       <= n_p1;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_base     <= n_base;
        r_waddr    <= n_waddr;
        r_result   <= n_result;
        r_out_data <= n_out_data;
    end

`ifndef SYNTHESIS
    // every store write lands inside the store
    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (CMP_W'(mem_waddr) < CMP_W'(STORE)))
        else $error("store write beyond the last byte");

    // no command is taken during the clearing pass
    a_init_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !i_cmd.ready)
        else $error("command taken while clearing");

    // a response only appears out of the done step
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state == S_DONE))
        else $error("response raised outside done step");

    // the walk stays at or below the last page and last column of the clipped range
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ((r_page <= r_p1) && (r_col <= r_x1)))
        else $error("walk left the clipped rectangle");
`endif

endmodule

FILE: design/mfde_clip.sv
// ----------------------------------------------------------------------------
// mfde_clip: rectangle clipper
// Clips one rectangle against the screen and gives column and page ranges.
// ----------------------------------------------------------------------------
module mfde_clip import mfde_pkg::*; #(
    parameter int WIDTH_PX  = DEF_WIDTH_PX,
    parameter int HEIGHT_PX = DEF_HEIGHT_PX
) (
    input  logic [COORD_W:0]   i_xs,
    input  logic [COORD_W:0]   i_ys,
    input  logic [COORD_W-1:0] i_ew,
    input  logic [COORD_W-1:0] i_eh,
    output t_clip              o_clip
);

    localparam int EXT_W = COORD_W + 2;

    logic [EXT_W-1:0]   xe;
    logic [EXT_W-1:0]   ye;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;

    // far edges at full width; they wrap only for a zero extent, which is flagged empty
    assign xe = EXT_W'(i_xs) + EXT_W'(i_ew) - EXT_W'(1);
    assign ye = EXT_W'(i_ys) + EXT_W'(i_eh) - EXT_W'(1);

    // clip against the screen
    always_comb begin
        o_clip.empty = (i_ew == '0) || (i_eh == '0)
                    || (EXT_W'(i_xs) >= EXT_W'(WIDTH_PX))
                    || (EXT_W'(i_ys) >= EXT_W'(HEIGHT_PX));
        o_clip.x0 = i_xs[COORD_W-1:0];
        o_clip.x1 = (xe >= EXT_W'(WIDTH_PX)) ? COORD_W'(WIDTH_PX - 1) : xe[COORD_W-1:0];
        y0 = i_ys[COORD_W-1:0];
        y1 = (ye >= EXT_W'(HEIGHT_PX)) ? COORD_W'(HEIGHT_PX - 1) : ye[COORD_W-1:0];
        o_clip.p0 = y0[COORD_W-1:ROW_IDX_W];
        o_clip.p1 = y1[COORD_W-1:ROW_IDX_W];
        o_clip.lo = y0[ROW_IDX_W-1:0];
        o_clip.hi = y1[ROW_IDX_W-1:0];
    end

endmodule

FILE: design/mfde_ram.sv
// ----------------------------------------------------------------------------
// mfde_ram: frame byte store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mfde_ram import mfde_pkg::*; #(
    parameter int DEPTH  = DEF_WIDTH_PX * ((DEF_HEIGHT_PX + 7) / 8),
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
